// File: design/trws_pkg.sv
// Shared types, constants and helpers for the timed register write sequencer.
// Used by every module in the design folder; depends on nothing else.
package trws_pkg;

    localparam int QUEUE_BYTES = 1024;
    localparam int ADDR_W      = $clog2(QUEUE_BYTES);
    localparam int CNT_W       = $clog2(QUEUE_BYTES + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;
    localparam int LEVEL_W     = 11;
    localparam int OUT_W       = 48;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_SLOT = 2'd2;

    localparam logic [7:0] HOST_RESET = 8'hc0;
    localparam logic [7:0] HOST_WRITE = 8'hc1;
    localparam logic [7:0] HOST_QUERY = 8'hc2;
    localparam logic [7:0] SUB_SLEEP  = 8'hd0;
    localparam logic [7:0] SUB_WRITE  = 8'hd1;
    localparam logic [7:0] SUB_CLOSE  = 8'hd2;

    localparam logic [1:0] CODE_OK     = 2'd0;
    localparam logic [1:0] CODE_INVAL  = 2'd1;
    localparam logic [1:0] CODE_OVERFL = 2'd2;

    localparam logic [2:0] PH_CMD     = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_SUB     = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    localparam logic [LEVEL_W-1:0] CAPACITY_REPORT = LEVEL_W'(QUEUE_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_LO,
        ST_HI
    } play_state_t;

    typedef struct packed {
        logic               underrun;
        logic               chip_reset;
        logic [7:0]         write_data;
        logic [7:0]         write_reg;
        logic               write_valid;
        logic [LEVEL_W-1:0] queue_level;
        logic [LEVEL_W-1:0] queue_capacity;
        logic               query_valid;
        logic [1:0]         resp_code;
        logic               resp_valid;
    } result_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr);
        logic [ADDR_W-1:0] nxt;
        if (ptr == ADDR_W'(QUEUE_BYTES - 1))
            nxt = '0;
        else
            nxt = ptr + ADDR_W'(1);
        return nxt;
    endfunction

    function automatic logic [1:0] sub_len(input logic [7:0] c);
        logic [1:0] len;
        if (c == SUB_SLEEP || c == SUB_WRITE)
            len = 2'd3;
        else
            len = 2'd1;
        return len;
    endfunction

endpackage

// File: design/trws_fifo_mem.sv
// Byte store of the command queue: one port, registered read data.
// Depends on trws_pkg for the depth and the request struct.
module trws_fifo_mem (
    input  logic              clk,
    input  trws_pkg::mem_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [trws_pkg::QUEUE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem[req.addr] <= req.wdata;
            else
                rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/trws_ctrl.sv
// Host frame parser, tick handling and playback engine around the queue store.
// Depends on trws_pkg; drives trws_fifo_mem and feeds trws_out_queue.
module trws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_type,
    input  logic [7:0]             in_byte,
    input  logic                   room,
    output logic                   res_valid,
    output trws_pkg::result_t      res,
    output trws_pkg::mem_req_t     mem_req,
    input  logic [7:0]             mem_rdata
);

    trws_pkg::play_state_t state_reg, state_next;

    logic [trws_pkg::ADDR_W-1:0] wptr_reg, wptr_next;
    logic [trws_pkg::ADDR_W-1:0] rptr_reg, rptr_next;
    logic [trws_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [15:0]                 sleep_reg, sleep_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [7:0]                  host_cmd_reg, host_cmd_next;
    logic [7:0]                  frame_left_reg, frame_left_next;
    logic [1:0]                  sub_left_reg, sub_left_next;
    logic [7:0]                  cmd_reg, cmd_next;
    logic [7:0]                  lo_reg, lo_next;

    logic                        accept;
    logic                        push_en;
    logic                        sub_done;
    logic [trws_pkg::CMP_W-1:0]  avail;
    logic [trws_pkg::CMP_W-1:0]  byte_ext;
    logic [1:0]                  in_len;
    logic [1:0]                  head_len;

    assign in_ready = (state_reg == trws_pkg::ST_IDLE) && room;
    assign accept   = in_valid && in_ready;
    assign avail    = trws_pkg::CMP_W'(trws_pkg::QUEUE_BYTES) - trws_pkg::CMP_W'(fill_reg);
    assign byte_ext = trws_pkg::CMP_W'(in_byte);
    assign in_len   = trws_pkg::sub_len(in_byte);
    assign head_len = trws_pkg::sub_len(mem_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= trws_pkg::ST_IDLE;
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            fill_reg       <= '0;
            sleep_reg      <= '0;
            phase_reg      <= trws_pkg::PH_CMD;
            host_cmd_reg   <= '0;
            frame_left_reg <= '0;
            sub_left_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wptr_reg       <= wptr_next;
            rptr_reg       <= rptr_next;
            fill_reg       <= fill_next;
            sleep_reg      <= sleep_next;
            phase_reg      <= phase_next;
            host_cmd_reg   <= host_cmd_next;
            frame_left_reg <= frame_left_next;
            sub_left_reg   <= sub_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        lo_reg  <= lo_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        fill_next       = fill_reg;
        sleep_next      = sleep_reg;
        phase_next      = phase_reg;
        host_cmd_next   = host_cmd_reg;
        frame_left_next = frame_left_reg;
        sub_left_next   = sub_left_reg;
        cmd_next        = cmd_reg;
        lo_next         = lo_reg;
        res_valid       = 1'b0;
        res             = '0;
        mem_req         = '0;
        push_en         = 1'b0;
        sub_done        = 1'b0;

        case (state_reg)
            trws_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_type)
                        trws_pkg::REQ_BYTE:
                        begin
                            res_valid = 1'b1;
                            case (phase_reg)
                                trws_pkg::PH_LEN:
                                begin
                                    phase_next = trws_pkg::PH_CMD;
                                    if (byte_ext > avail)
                                    begin
                                        res.resp_valid = 1'b1;
                                        res.resp_code  = trws_pkg::CODE_OVERFL;
                                    end
                                    else if (host_cmd_reg == trws_pkg::HOST_RESET)
                                    begin
                                        wptr_next      = '0;
                                        rptr_next      = '0;
                                        fill_next      = '0;
                                        res.chip_reset = 1'b1;
                                        res.resp_valid = 1'b1;
                                        res.resp_code  = trws_pkg::CODE_OK;
                                    end
                                    else if (host_cmd_reg == trws_pkg::HOST_QUERY)
                                    begin
                                        res.resp_valid     = 1'b1;
                                        res.resp_code      = trws_pkg::CODE_OK;
                                        res.query_valid    = 1'b1;
                                        res.queue_capacity = trws_pkg::CAPACITY_REPORT;
                                        res.queue_level    = trws_pkg::LEVEL_W'(fill_reg);
                                    end
                                    else if (host_cmd_reg == trws_pkg::HOST_WRITE)
                                    begin
                                        frame_left_next = in_byte;
                                        if (in_byte == 8'd0)
                                        begin
                                            res.resp_valid = 1'b1;
                                            res.resp_code  = trws_pkg::CODE_OK;
                                        end
                                        else
                                        begin
                                            phase_next = trws_pkg::PH_SUB;
                                        end
                                    end
                                    else
                                    begin
                                        res.resp_valid = 1'b1;
                                        res.resp_code  = trws_pkg::CODE_INVAL;
                                    end
                                end
                                trws_pkg::PH_SUB:
                                begin
                                    if ((in_byte != trws_pkg::SUB_SLEEP &&
                                         in_byte != trws_pkg::SUB_WRITE &&
                                         in_byte != trws_pkg::SUB_CLOSE) ||
                                        (frame_left_reg < 8'(in_len)))
                                    begin
                                        res.resp_valid = 1'b1;
                                        res.resp_code  = trws_pkg::CODE_INVAL;
                                        phase_next     = trws_pkg::PH_CMD;
                                    end
                                    else
                                    begin
                                        frame_left_next = frame_left_reg - 8'(in_len);
                                        push_en         = 1'b1;
                                        sub_left_next   = in_len - 2'd1;
                                        if (in_len != 2'd1)
                                            phase_next = trws_pkg::PH_DATA;
                                        else
                                            sub_done = 1'b1;
                                    end
                                end
                                trws_pkg::PH_DATA, trws_pkg::PH_DISCARD:
                                begin
                                    push_en       = (phase_reg == trws_pkg::PH_DATA);
                                    sub_left_next = sub_left_reg - 2'd1;
                                    sub_done      = (sub_left_next == 2'd0);
                                end
                                default:
                                begin
                                    host_cmd_next = in_byte;
                                    phase_next    = trws_pkg::PH_LEN;
                                end
                            endcase
                        end
                        trws_pkg::REQ_TICK:
                        begin
                            res_valid = 1'b1;
                            if (sleep_reg != 16'd0)
                                sleep_next = sleep_reg - 16'd1;
                        end
                        trws_pkg::REQ_SLOT:
                        begin
                            if (fill_reg == '0 || sleep_reg != 16'd0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                mem_req.en   = 1'b1;
                                mem_req.addr = rptr_reg;
                                state_next   = trws_pkg::ST_HEAD;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            trws_pkg::ST_HEAD:
            begin
                state_next = trws_pkg::ST_IDLE;
                if (fill_reg < trws_pkg::CNT_W'(head_len))
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    rptr_next = trws_pkg::ptr_inc(rptr_reg);
                    fill_next = fill_reg - trws_pkg::CNT_W'(1);
                    if (mem_rdata == trws_pkg::SUB_CLOSE)
                    begin
                        wptr_next      = '0;
                        rptr_next      = '0;
                        fill_next      = '0;
                        res_valid      = 1'b1;
                        res.chip_reset = 1'b1;
                        res.resp_valid = 1'b1;
                        res.resp_code  = trws_pkg::CODE_OK;
                        if (phase_reg == trws_pkg::PH_DATA)
                            phase_next = trws_pkg::PH_DISCARD;
                    end
                    else if (mem_rdata == trws_pkg::SUB_SLEEP ||
                             mem_rdata == trws_pkg::SUB_WRITE)
                    begin
                        cmd_next     = mem_rdata;
                        mem_req.en   = 1'b1;
                        mem_req.addr = trws_pkg::ptr_inc(rptr_reg);
                        state_next   = trws_pkg::ST_LO;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
            end
            trws_pkg::ST_LO:
            begin
                lo_next      = mem_rdata;
                rptr_next    = trws_pkg::ptr_inc(rptr_reg);
                fill_next    = fill_reg - trws_pkg::CNT_W'(1);
                mem_req.en   = 1'b1;
                mem_req.addr = trws_pkg::ptr_inc(rptr_reg);
                state_next   = trws_pkg::ST_HI;
            end
            trws_pkg::ST_HI:
            begin
                rptr_next  = trws_pkg::ptr_inc(rptr_reg);
                fill_next  = fill_reg - trws_pkg::CNT_W'(1);
                res_valid  = 1'b1;
                state_next = trws_pkg::ST_IDLE;
                if (cmd_reg == trws_pkg::SUB_SLEEP)
                begin
                    sleep_next = {mem_rdata, lo_reg};
                end
                else
                begin
                    res.write_valid = 1'b1;
                    res.write_reg   = lo_reg;
                    res.write_data  = mem_rdata;
                end
            end
            default:
            begin
                state_next = trws_pkg::ST_IDLE;
            end
        endcase

        if (push_en && fill_reg < trws_pkg::CNT_W'(trws_pkg::QUEUE_BYTES))
        begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = wptr_reg;
            mem_req.wdata = in_byte;
            wptr_next     = trws_pkg::ptr_inc(wptr_reg);
            fill_next     = fill_reg + trws_pkg::CNT_W'(1);
        end

        if (sub_done)
        begin
            if (frame_left_next == 8'd0)
            begin
                res.resp_valid = 1'b1;
                res.resp_code  = trws_pkg::CODE_OK;
                phase_next     = trws_pkg::PH_CMD;
            end
            else
            begin
                phase_next = trws_pkg::PH_SUB;
            end
        end

        if (res_valid)
            res.underrun = (fill_next == '0);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= trws_pkg::QUEUE_BYTES)
    else $error("Queue level exceeds the queue size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(rptr_reg) + int'(fill_reg) == int'(wptr_reg)) ||
        (int'(rptr_reg) + int'(fill_reg) == int'(wptr_reg) + trws_pkg::QUEUE_BYTES))
    else $error("Queue pointers and level disagree.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trws_pkg::ST_HEAD) |-> (fill_reg != '0 && sleep_reg == 16'd0))
    else $error("Playback started on an empty queue or during a sleep.");

endmodule

// File: design/trws_out_queue.sv
// Two-entry result queue that decouples the engine from the output channel.
// Depends on trws_pkg for the result struct.
module trws_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  trws_pkg::result_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output trws_pkg::result_t out_data
);

    trws_pkg::result_t slot0_reg, slot0_next;
    trws_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign pop       = (count_reg != 2'd0) && out_ready;
    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = push_data;
                end
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            default:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
    else $error("Result pushed into a full output queue.");

endmodule

// File: design/timed_register_write_sequencer.sv
// Timed register write sequencer: host bytes, ticks and playback slots in, one result word out.
// Host bytes, ticks and empty slots finish in idle; a slot popping close or nothing reads
// the head byte, one popping sleep or write the low and high bytes too, one queue byte read
// per cycle from the single-port store. Results are registered in a two-entry output queue.
// Reset clears the pointers, level, sleep counter and parser; the byte store is not cleared.
// Depends on trws_pkg, trws_fifo_mem, trws_ctrl and trws_out_queue.
module timed_register_write_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte[7:0]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // resp_valid, resp_code[2:1], query_valid, queue_capacity[14:4], queue_level[25:15],
    // write_valid, write_reg[34:27], write_data[42:35], chip_reset, underrun, zeros
    output logic [trws_pkg::OUT_W-1:0] m_axis_tdata
);

    trws_pkg::mem_req_t mem_req;
    trws_pkg::result_t  res;
    trws_pkg::result_t  out_res;
    logic [7:0]         mem_rdata;
    logic               res_valid;
    logic               room;

    trws_fifo_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    trws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_type   (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .room      (room),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    trws_out_queue u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = trws_pkg::OUT_W'(out_res);

endmodule

// File: tb/timed_register_write_sequencer_tb.sv
// Self-checking testbench for the timed register write sequencer stream interface.
// It needs trws_pkg and the design files. A scoreboard class predicts every output word.
module timed_register_write_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class sequencer_scoreboard;
        logic [7:0]        queue_mem [trws_pkg::QUEUE_BYTES];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       level;
        int unsigned       sleep_left;
        logic [2:0]        parse_phase;
        logic [7:0]        host_cmd;
        int unsigned       frame_left;
        int unsigned       sub_left;
        trws_pkg::result_t owed[$];
        int unsigned       errors;

        function new();
            head = 0;
            tail = 0;
            level = 0;
            sleep_left = 0;
            parse_phase = trws_pkg::PH_CMD;
            host_cmd = '0;
            frame_left = 0;
            sub_left = 0;
            errors = 0;
        endfunction

        function int unsigned cmd_bytes(input logic [7:0] c);
            return (c == trws_pkg::SUB_SLEEP || c == trws_pkg::SUB_WRITE) ? 3 : 1;
        endfunction

        function void clear_queue();
            head = 0;
            tail = 0;
            level = 0;
        endfunction

        function void push_byte(input logic [7:0] v);
            if (level >= trws_pkg::QUEUE_BYTES)
                return;
            queue_mem[tail] = v;
            tail = (tail + 1) % trws_pkg::QUEUE_BYTES;
            level++;
        endfunction

        function logic [7:0] pop_byte();
            logic [7:0] v;
            if (level == 0)
                return '0;
            v = queue_mem[head];
            head = (head + 1) % trws_pkg::QUEUE_BYTES;
            level--;
            return v;
        endfunction

        function void answer(inout trws_pkg::result_t r, input logic [1:0] code);
            r.resp_valid = 1'b1;
            r.resp_code = code;
        endfunction

        function void end_of_sub(inout trws_pkg::result_t r);
            if (frame_left == 0)
            begin
                answer(r, trws_pkg::CODE_OK);
                parse_phase = trws_pkg::PH_CMD;
            end
            else
            begin
                parse_phase = trws_pkg::PH_SUB;
            end
        endfunction

        function void host_byte(input logic [7:0] b, inout trws_pkg::result_t r);
            int unsigned len;
            case (parse_phase)
                trws_pkg::PH_LEN:
                begin
                    parse_phase = trws_pkg::PH_CMD;
                    if (int'(b) > trws_pkg::QUEUE_BYTES - int'(level))
                    begin
                        answer(r, trws_pkg::CODE_OVERFL);
                    end
                    else if (host_cmd == trws_pkg::HOST_RESET)
                    begin
                        clear_queue();
                        r.chip_reset = 1'b1;
                        answer(r, trws_pkg::CODE_OK);
                    end
                    else if (host_cmd == trws_pkg::HOST_QUERY)
                    begin
                        answer(r, trws_pkg::CODE_OK);
                        r.query_valid = 1'b1;
                        r.queue_capacity = trws_pkg::LEVEL_W'(trws_pkg::QUEUE_BYTES);
                        r.queue_level = trws_pkg::LEVEL_W'(level);
                    end
                    else if (host_cmd == trws_pkg::HOST_WRITE)
                    begin
                        frame_left = b;
                        if (b == 0)
                            answer(r, trws_pkg::CODE_OK);
                        else
                            parse_phase = trws_pkg::PH_SUB;
                    end
                    else
                    begin
                        answer(r, trws_pkg::CODE_INVAL);
                    end
                end
                trws_pkg::PH_SUB:
                begin
                    len = cmd_bytes(b);
                    if ((b != trws_pkg::SUB_SLEEP && b != trws_pkg::SUB_WRITE &&
                         b != trws_pkg::SUB_CLOSE) || frame_left < len)
                    begin
                        answer(r, trws_pkg::CODE_INVAL);
                        parse_phase = trws_pkg::PH_CMD;
                    end
                    else
                    begin
                        frame_left -= len;
                        push_byte(b);
                        sub_left = len - 1;
                        if (sub_left != 0)
                            parse_phase = trws_pkg::PH_DATA;
                        else
                            end_of_sub(r);
                    end
                end
                trws_pkg::PH_DATA, trws_pkg::PH_DISCARD:
                begin
                    if (parse_phase == trws_pkg::PH_DATA)
                        push_byte(b);
                    sub_left = (sub_left - 1) & 3;
                    if (sub_left == 0)
                        end_of_sub(r);
                end
                default:
                begin
                    host_cmd = b;
                    parse_phase = trws_pkg::PH_LEN;
                end
            endcase
        endfunction

        function void play_slot(inout trws_pkg::result_t r);
            logic [7:0] c;
            logic [7:0] lo;
            logic [7:0] hi;
            if (level == 0 || sleep_left != 0)
                return;
            c = queue_mem[head];
            if (level < cmd_bytes(c))
                return;
            void'(pop_byte());
            if (c == trws_pkg::SUB_SLEEP)
            begin
                lo = pop_byte();
                hi = pop_byte();
                sleep_left = {hi, lo};
            end
            else if (c == trws_pkg::SUB_WRITE)
            begin
                r.write_reg = pop_byte();
                r.write_data = pop_byte();
                r.write_valid = 1'b1;
            end
            else if (c == trws_pkg::SUB_CLOSE)
            begin
                clear_queue();
                if (parse_phase == trws_pkg::PH_DATA)
                    parse_phase = trws_pkg::PH_DISCARD;
                r.chip_reset = 1'b1;
                answer(r, trws_pkg::CODE_OK);
            end
        endfunction

        function void note_request(input logic [1:0] req, input logic [7:0] b);
            trws_pkg::result_t r;
            r = '0;
            case (req)
                trws_pkg::REQ_BYTE:
                begin
                    host_byte(b, r);
                end
                trws_pkg::REQ_TICK:
                begin
                    if (sleep_left != 0)
                        sleep_left--;
                end
                trws_pkg::REQ_SLOT:
                begin
                    play_slot(r);
                end
                default:
                begin
                end
            endcase
            r.underrun = (level == 0);
            owed.push_back(r);
        endfunction

        function void compare(input string name, input int unsigned want,
                              input int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(input logic [trws_pkg::OUT_W-1:0] word);
            trws_pkg::result_t got;
            trws_pkg::result_t want;
            got = trws_pkg::result_t'(word[$bits(trws_pkg::result_t)-1:0]);
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word, expected none, got %h", $time, word);
                return;
            end
            want = owed.pop_front();
            compare("resp_valid", want.resp_valid, got.resp_valid);
            compare("resp_code", want.resp_code, got.resp_code);
            compare("query_valid", want.query_valid, got.query_valid);
            compare("queue_capacity", want.queue_capacity, got.queue_capacity);
            compare("queue_level", want.queue_level, got.queue_level);
            compare("write_valid", want.write_valid, got.write_valid);
            compare("write_reg", want.write_reg, got.write_reg);
            compare("write_data", want.write_data, got.write_data);
            compare("chip_reset", want.chip_reset, got.chip_reset);
            compare("underrun", want.underrun, got.underrun);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata;
    logic [1:0]                 s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [trws_pkg::OUT_W-1:0] m_axis_tdata;

    sequencer_scoreboard board;
    int unsigned         words_sent;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;

    timed_register_write_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500us;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [1:0] req, input logic [7:0] b);
        case ((words_sent / 200) % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 79;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 79;
            end
            default:
            begin
                send_idle_pct = 7;
                recv_stall_pct = 7;
            end
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= b;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(req, b);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(trws_pkg::REQ_BYTE, b);
    endtask

    task automatic slot();
        send_word(trws_pkg::REQ_SLOT, 8'($urandom_range(255)));
    endtask

    task automatic tick();
        send_word(trws_pkg::REQ_TICK, 8'($urandom_range(255)));
    endtask

    task automatic bulk_write_frame(input int unsigned n_writes);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'(3 * n_writes));
        repeat (n_writes)
        begin
            send_byte(trws_pkg::SUB_WRITE);
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic random_write_frame();
        logic [7:0]  body[$];
        int unsigned cmd_pos[$];
        int unsigned n_sub;
        int unsigned len;
        int unsigned pick;
        n_sub = $urandom_range(1, 6);
        repeat (n_sub)
        begin
            pick = $urandom_range(99);
            cmd_pos.push_back(body.size());
            if (pick < 60)
            begin
                body.push_back(trws_pkg::SUB_WRITE);
                body.push_back(8'($urandom_range(255)));
                body.push_back(8'($urandom_range(255)));
            end
            else if (pick < 85)
            begin
                body.push_back(trws_pkg::SUB_SLEEP);
                body.push_back(8'($urandom_range(6)));
                body.push_back(8'h00);
            end
            else
            begin
                body.push_back(trws_pkg::SUB_CLOSE);
            end
        end
        len = body.size();
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(2))
                0:
                begin
                    body[cmd_pos[$urandom_range(cmd_pos.size() - 1)]] =
                        8'($urandom_range(255));
                end
                1:
                begin
                    len = len - 1;
                end
                default:
                begin
                    len = len + $urandom_range(1, 3);
                end
            endcase
        end
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'(len));
        foreach (body[i])
        begin
            if ($urandom_range(99) < 10)
            begin
                if ($urandom_range(1))
                    slot();
                else
                    tick();
            end
            send_byte(body[i]);
        end
    endtask

    task automatic playback_burst();
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(99) < (board.sleep_left > 20 ? 90 : 30))
                tick();
            else
                slot();
        end
    endtask

    task automatic random_traffic(input int unsigned stop_at);
        int unsigned pick;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                random_write_frame();
            end
            else if (pick < 75)
            begin
                playback_burst();
            end
            else if (pick < 83)
            begin
                send_byte(trws_pkg::HOST_QUERY);
                send_byte($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(3)));
            end
            else if (pick < 87)
            begin
                send_byte(trws_pkg::HOST_RESET);
                send_byte(8'($urandom_range(3)));
            end
            else if (pick < 92)
            begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(8)));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic deep_queue_pass();
        while (board.parse_phase != trws_pkg::PH_CMD)
            send_byte(8'h00);
        send_byte(trws_pkg::HOST_RESET);
        send_byte(8'h00);
        while (board.sleep_left != 0)
            tick();
        repeat (3) bulk_write_frame(85);
        repeat (2) slot();
        bulk_write_frame(85);
        bulk_write_frame(3);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h01);
        send_byte(trws_pkg::SUB_CLOSE);
        send_byte(trws_pkg::HOST_QUERY);
        send_byte(8'h00);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h01);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h00);
        send_byte(trws_pkg::HOST_RESET);
        send_byte(8'hff);
        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (2) slot();
        send_byte(trws_pkg::HOST_QUERY);
        send_byte(8'h00);
        send_byte(trws_pkg::HOST_RESET);
        send_byte(8'h00);
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        board = new();
        words_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= trws_pkg::REQ_BYTE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(trws_pkg::HOST_QUERY);
        send_byte(8'h00);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h07);
        send_byte(trws_pkg::SUB_WRITE);
        send_byte(8'hff);
        slot();
        send_byte(8'h00);
        send_byte(trws_pkg::SUB_SLEEP);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(trws_pkg::SUB_CLOSE);
        slot();
        slot();
        slot();
        tick();
        slot();
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h00);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h02);
        send_byte(8'hff);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h02);
        send_byte(trws_pkg::SUB_WRITE);
        send_byte(trws_pkg::HOST_RESET);
        send_byte(8'h00);
        send_word(2'd3, 8'ha5);
        send_byte(trws_pkg::HOST_WRITE);
        send_byte(8'h04);
        send_byte(trws_pkg::SUB_CLOSE);
        send_byte(trws_pkg::SUB_WRITE);
        slot();
        send_byte(8'haa);
        send_byte(8'h55);

        random_traffic(90);
        deep_queue_pass();

        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
